// ===== rtl/rlb_pkg.sv =====
// ----------------------------------------------------------------------------
// rlb_pkg: shared types and constants for the RGB layer blend
// Blend mode codes and the per-lane payload carried between pipeline stages.
// ----------------------------------------------------------------------------
package rlb_pkg;

  localparam int ChanW = 8;
  localparam int ProdW = 2 * ChanW;

  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [ChanW-1:0] ChanHalf = 8'd127;

  // blend mode register codes
  typedef enum logic [1:0] {
    MODE_MULTIPLY = 2'd0,
    MODE_SUBTRACT = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } mode_t;

  // stage 1 -> 2: multiplier operands and output shaping flags
  typedef struct packed {
    logic [ChanW-1:0] x;
    logic [ChanW-1:0] y;
    logic             dbl;
    logic             inv;
    logic             sub;
    logic [ChanW-1:0] diff;
  } s1_t;

  // stage 2 -> 3: scaled product
  typedef struct packed {
    logic [ProdW-1:0] p;
    logic             inv;
    logic             sub;
    logic [ChanW-1:0] diff;
  } s2_t;

  // stage 3 -> 4: rounded numerator and quotient estimate
  typedef struct packed {
    logic [ProdW-1:0] v;
    logic [ChanW:0]   q;
    logic             inv;
    logic             sub;
    logic [ChanW-1:0] diff;
  } s3_t;

endpackage

// ===== rtl/rgb_layer_blend.sv =====
// ----------------------------------------------------------------------------
// rgb_layer_blend: per-channel blend of a top and a bottom RGB pixel
// Four register stages: operand select, multiply, divide estimate, correct.
// Throughput: one word per cycle while out_tready does not stall the output stage.
// Reset: clears stage valid bits and sets the blend mode to multiply.
// ----------------------------------------------------------------------------
module rgb_layer_blend (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: blend mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // a_blue, a_green, a_red, b_blue, b_green, b_red (8 bits each)
  input  logic [47:0] in_tdata,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_blue, out_green, out_red (8 bits each)
  output logic [23:0] out_tdata
);
  import rlb_pkg::*;

  localparam int NumChan = 3;

  mode_t mode_r;
  logic  v1_r, v2_r, v3_r, v4_r;
  logic  en1, en2, en3, en4;

  s1_t s1_r [NumChan];
  s2_t s2_r [NumChan];
  s3_t s3_r [NumChan];

  // mode register; the user must write it only between runs, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MULTIPLY;
    end else if (cfg_valid) begin
      mode_r <= mode_t'(cfg_data);
    end
  end

  // advance a stage when it is empty or its successor moves
  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_tvalid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  assign out_tvalid = v4_r;

  // one lane per colour channel
  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lane
    rlb_prep u_prep (
      .clk  (clk),
      .en   (en1),
      .mode (mode_r),
      .a    (in_tdata[ch*ChanW +: ChanW]),
      .b    (in_tdata[(ch+NumChan)*ChanW +: ChanW]),
      .s1_r (s1_r[ch])
    );

    rlb_mul u_mul (
      .clk  (clk),
      .en   (en2),
      .s1   (s1_r[ch]),
      .s2_r (s2_r[ch])
    );

    rlb_div u_div (
      .clk  (clk),
      .en   (en3),
      .s2   (s2_r[ch]),
      .s3_r (s3_r[ch])
    );

    rlb_fix u_fix (
      .clk   (clk),
      .en    (en4),
      .s3    (s3_r[ch]),
      .res_r (out_tdata[ch*ChanW +: ChanW])
    );
  end

endmodule

// ===== rtl/rlb_prep.sv =====
// ----------------------------------------------------------------------------
// rlb_prep: operand preparation stage
// Picks multiplier operands per mode and works out the clamped difference.
// ----------------------------------------------------------------------------
module rlb_prep (
  input  logic                     clk,
  input  logic                     en,
  input  rlb_pkg::mode_t           mode,
  input  logic [rlb_pkg::ChanW-1:0] a,
  input  logic [rlb_pkg::ChanW-1:0] b,
  output rlb_pkg::s1_t             s1_r
);
  import rlb_pkg::*;

  s1_t s1_nxt;

  // select operands: direct for darkening, complements for lightening
  always_comb begin
    s1_nxt.x    = a;
    s1_nxt.y    = b;
    s1_nxt.dbl  = 1'b0;
    s1_nxt.inv  = 1'b0;
    s1_nxt.sub  = 1'b0;
    s1_nxt.diff = (a < b) ? '0 : (a - b);
    case (mode)
      MODE_MULTIPLY: begin
      end
      MODE_SUBTRACT: begin
        s1_nxt.sub = 1'b1;
      end
      MODE_SCREEN: begin
        s1_nxt.x   = ChanMax - a;
        s1_nxt.y   = ChanMax - b;
        s1_nxt.inv = 1'b1;
      end
      MODE_OVERLAY: begin
        s1_nxt.dbl = 1'b1;
        if (b > ChanHalf) begin
          s1_nxt.x   = ChanMax - a;
          s1_nxt.y   = ChanMax - b;
          s1_nxt.inv = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // hold while the next stage is blocked
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// ===== rtl/rlb_mul.sv =====
// ----------------------------------------------------------------------------
// rlb_mul: product stage
// One 8x8 multiply, doubled for overlay. Overlay operands stay below half
// scale on one side, so the doubled product still fits 16 bits.
// ----------------------------------------------------------------------------
module rlb_mul (
  input  logic         clk,
  input  logic         en,
  input  rlb_pkg::s1_t s1,
  output rlb_pkg::s2_t s2_r
);
  import rlb_pkg::*;

  s2_t              s2_nxt;
  logic [ProdW-1:0] prod;

  // multiply and optionally double
  always_comb begin
    prod        = ProdW'(s1.x) * ProdW'(s1.y);
    s2_nxt.p    = s1.dbl ? {prod[ProdW-2:0], 1'b0} : prod;
    s2_nxt.inv  = s1.inv;
    s2_nxt.sub  = s1.sub;
    s2_nxt.diff = s1.diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// ===== rtl/rlb_div.sv =====
// ----------------------------------------------------------------------------
// rlb_div: divide-by-255 estimate stage
// Adds the rounding offset and forms (v + v/256) / 256, which is at most one
// below floor(v/255); the final stage corrects it.
// ----------------------------------------------------------------------------
module rlb_div (
  input  logic         clk,
  input  logic         en,
  input  rlb_pkg::s2_t s2,
  output rlb_pkg::s3_t s3_r
);
  import rlb_pkg::*;

  s3_t              s3_nxt;
  logic [ProdW-1:0] v;
  logic [ProdW:0]   acc;

  // round offset, then reciprocal estimate
  always_comb begin
    v           = s2.p + ProdW'(ChanHalf);
    acc         = {1'b0, v} + {{(ChanW+1){1'b0}}, v[ProdW-1:ChanW]};
    s3_nxt.v    = v;
    s3_nxt.q    = acc[ProdW:ChanW];
    s3_nxt.inv  = s2.inv;
    s3_nxt.sub  = s2.sub;
    s3_nxt.diff = s2.diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ===== rtl/rlb_fix.sv =====
// ----------------------------------------------------------------------------
// rlb_fix: quotient correction and output select
// Checks the remainder, bumps the estimate once if needed, and shapes the
// channel result for the selected mode.
// ----------------------------------------------------------------------------
module rlb_fix (
  input  logic                      clk,
  input  logic                      en,
  input  rlb_pkg::s3_t              s3,
  output logic [rlb_pkg::ChanW-1:0] res_r
);
  import rlb_pkg::*;

  logic [ChanW-1:0] res_nxt;
  logic [ProdW:0]   q_mul;
  logic [ProdW:0]   rem;
  logic [ChanW:0]   q;

  // remainder against 255*q, one correction step
  always_comb begin
    q_mul = ({{(ProdW-ChanW){1'b0}}, s3.q} << ChanW) - {{(ProdW-ChanW){1'b0}}, s3.q};
    rem   = {1'b0, s3.v} - q_mul;
    q     = (rem >= (ProdW+1)'(ChanMax)) ? s3.q + 1'b1 : s3.q;
    if (s3.sub) begin
      res_nxt = s3.diff;
    end else if (s3.inv) begin
      res_nxt = ChanMax - q[ChanW-1:0];
    end else begin
      res_nxt = q[ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== verif/blend_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blend_checker: scoreboard for the RGB layer blend
// Follows the mode register, predicts each blended pixel from the accepted
// input words, and compares the output words with the oldest prediction.
// ----------------------------------------------------------------------------
module blend_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // a_blue, a_green, a_red, b_blue, b_green, b_red (8 bits each)
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // out_blue, out_green, out_red (8 bits each)
  input  logic [23:0] out_tdata,
  output int          mismatches,
  output int          words_waiting
);
  import rlb_pkg::*;

  localparam int unsigned LevelMax  = 255;
  localparam int unsigned LevelHalf = 127;
  localparam int          ReportMax = 10;

  mode_t       active_mode;
  logic [23:0] blended_pixels[$];
  logic [23:0] head_pixel;
  int          fail_total;
  int          queue_depth;
  int          words_out;

  assign mismatches    = fail_total;
  assign words_waiting = queue_depth;

  // round x/255 to nearest; halves cannot occur since 255 is odd
  function automatic int unsigned round_div255(int unsigned x);
    return (x + LevelHalf) / LevelMax;
  endfunction

  function automatic logic [7:0] blend_lane(mode_t mode, logic [7:0] a, logic [7:0] b);
    int unsigned ai;
    int unsigned bi;
    int unsigned res;
    ai = a;
    bi = b;
    case (mode)
      MODE_MULTIPLY: res = round_div255(ai * bi);
      MODE_SUBTRACT: res = (ai < bi) ? 0 : ai - bi;
      MODE_SCREEN:   res = LevelMax - round_div255((LevelMax - ai) * (LevelMax - bi));
      default: begin
        // overlay keys on the bottom layer: dark half multiplies, light half screens
        if (bi <= LevelHalf)
          res = round_div255(2 * ai * bi);
        else
          res = LevelMax - round_div255(2 * (LevelMax - ai) * (LevelMax - bi));
      end
    endcase
    return res[7:0];
  endfunction

  function automatic logic [23:0] blend_pixel(mode_t mode, logic [47:0] pair);
    logic [23:0] px;
    for (int ch = 0; ch < 3; ch++)
      px[8*ch +: 8] = blend_lane(mode, pair[8*ch +: 8], pair[24 + 8*ch +: 8]);
    return px;
  endfunction

  function automatic string lane_name(int ch);
    case (ch)
      0:       return "blue";
      1:       return "green";
      default: return "red";
    endcase
  endfunction

  // track the mode, queue predictions and compare each output word
  always @(posedge clk) begin
    if (!rst_n) begin
      active_mode = MODE_MULTIPLY;
      blended_pixels.delete();
      fail_total = 0;
      words_out  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (blended_pixels.size() == 0) begin
          if (fail_total < ReportMax)
            $display("blend error: output word %0d (%h) with nothing outstanding",
                     words_out, out_tdata);
          fail_total++;
        end else begin
          head_pixel = blended_pixels.pop_front();
          for (int ch = 0; ch < 3; ch++) begin
            if (out_tdata[8*ch +: 8] !== head_pixel[8*ch +: 8]) begin
              if (fail_total < ReportMax)
                $display("blend mismatch: word %0d %s lane, mode %s: expected %0d got %0d",
                         words_out, lane_name(ch), active_mode.name(),
                         head_pixel[8*ch +: 8], out_tdata[8*ch +: 8]);
              fail_total++;
            end
          end
        end
        words_out++;
      end
      // append the prediction at the tail of the queue
      if (in_tvalid && in_tready)
        blended_pixels.insert(blended_pixels.size(), blend_pixel(active_mode, in_tdata));
      if (cfg_valid && cfg_ready)
        active_mode = mode_t'(cfg_data);
    end
    queue_depth = blended_pixels.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the RGB layer blend
// Runs corner pixel pairs under every blend mode, then random phases with
// idle gaps, a long output hold-off and drained pauses around mode changes.
// ----------------------------------------------------------------------------
module testbench;
  import rlb_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;
  localparam int Phases      = 8;
  localparam int PhaseWords  = 92;
  localparam int MaxGap      = 6;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  int          fail_count;
  int          words_waiting;
  int          cycle_count;
  int          words_sent;
  int          mode_writes;
  bit          send_gaps;
  bit          recv_gaps;
  bit          hold_request;
  logic [47:0] corner_pairs[6];

  rgb_layer_blend dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  blend_checker blend_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (fail_count),
    .words_waiting (words_waiting)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stop a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [47:0] pack_pair(logic [7:0] ab, logic [7:0] ag, logic [7:0] ar,
                                            logic [7:0] bb, logic [7:0] bg, logic [7:0] br);
    return {br, bg, bb, ar, ag, ab};
  endfunction

  // bias towards the rails and the overlay split point
  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(126, 129));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] random_pair();
    return pack_pair(random_level(), random_level(), random_level(),
                     random_level(), random_level(), random_level());
  endfunction

  // offer one word after a random gap; hold valid until it is taken
  task automatic send_pair(logic [47:0] pair);
    int gap;
    gap = send_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pair;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding pixel
  task automatic await_drain();
    in_tvalid = 1'b0;
    while (words_waiting != 0) @(negedge clk);
  endtask

  task automatic write_mode(mode_t mode);
    await_drain();
    repeat (DrainCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    mode_writes++;
  endtask

  // output side: random stalls per word, plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = recv_gaps ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    mode_t phase_mode;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = MODE_MULTIPLY;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    words_sent   = 0;
    mode_writes  = 0;
    send_gaps    = 1'b1;
    recv_gaps    = 1'b1;
    hold_request = 1'b0;

    // corner pairs: rails, near-rails and the overlay split at 127/128
    corner_pairs[0] = pack_pair(8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd255);
    corner_pairs[1] = pack_pair(8'd0,   8'd128, 8'd200, 8'd255, 8'd127, 8'd128);
    corner_pairs[2] = pack_pair(8'd127, 8'd128, 8'd1,   8'd127, 8'd128, 8'd254);
    corner_pairs[3] = pack_pair(8'd255, 8'd255, 8'd0,   8'd127, 8'd128, 8'd0);
    corner_pairs[4] = pack_pair(8'd1,   8'd254, 8'd170, 8'd254, 8'd1,   8'd85);
    corner_pairs[5] = pack_pair(8'd255, 8'd0,   8'd64,  8'd128, 8'd127, 8'd255);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset mode first, then each other mode
    for (int md = 0; md < 4; md++) begin
      if (md != 0)
        write_mode(mode_t'(md));
      for (int k = 0; k < 6; k++)
        send_pair(corner_pairs[k]);
    end

    // random phases, each under its own mode and flow-control mix
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0:       phase_mode = MODE_OVERLAY;
        1:       phase_mode = MODE_MULTIPLY;
        2:       phase_mode = MODE_SCREEN;
        3:       phase_mode = MODE_SUBTRACT;
        default: phase_mode = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(phase_mode);
      send_gaps = (ph % 4 == 0) || (ph % 4 == 2);
      recv_gaps = (ph % 4 == 0) || (ph % 4 == 1);
      for (int k = 0; k < PhaseWords; k++) begin
        // hold the output back while words keep coming, so the pipe backs up
        if (ph == 1 && k == 10)
          hold_request = 1'b1;
        if (ph == 5 && k == PhaseWords / 2)
          await_drain();
        send_pair(random_pair());
      end
    end

    await_drain();
    repeat (DrainCycles) @(negedge clk);

    $display("Blend run: %0d pixel pairs, %0d mode writes, all four modes with corner levels",
             words_sent, mode_writes);
    $display("Flow control: random gaps both sides, a %0d-cycle output hold-off, drained pauses",
             HoldCycles);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
